/* design/barometric_sensor_compensation_macros.svh */
// Assertion macros shared by the checker.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BSC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication, disabled while in reset.
`define BSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

/* design/bsc_pkg.sv */
package bsc_pkg;

	localparam int unsigned DivSteps = 32;

	// Fixed compensation constants.
	localparam logic [31:0] CoefMg = 32'd3038;
	localparam logic [31:0] CoefMhNeg = 32'd7357;
	localparam logic [31:0] CoefMi = 32'd3791;
	localparam logic [31:0] B6Offset = 32'd4000;
	localparam logic [31:0] B7Limit = 32'h8000_0000;
	localparam logic [31:0] B4Offset = 32'd32768;
	localparam logic [31:0] T5Round = 32'd8;

	// Command codes of an input beat.
	localparam logic [1:0] CMD_RAW_TEMP = 2'd0;
	localparam logic [1:0] CMD_RAW_PRESS = 2'd1;
	localparam logic [1:0] CMD_SET_TEMP = 2'd2;
	localparam logic [1:0] CMD_SET_PRESS = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2 = 3'd3;
	localparam logic [2:0] REG_MC_MD = 3'd4;
	localparam logic [2:0] REG_OSS = 3'd5;
	localparam logic [2:0] REG_TDELTA = 3'd6;
	localparam logic [2:0] REG_PDELTA = 3'd7;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_T_MUL,
		OP_T_DEN,
		OP_T_CHK,
		OP_DIV,
		OP_T_B5,
		OP_T_TEMP,
		OP_P_B6,
		OP_P_SQ,
		OP_P_X1,
		OP_P_X2,
		OP_P_B3,
		OP_P_X1B,
		OP_P_X2B,
		OP_P_X3,
		OP_P_B4,
		OP_P_B7,
		OP_P_CHK,
		OP_P_QUO,
		OP_P_XS,
		OP_P_X1C,
		OP_P_X2C,
		OP_P_FIN,
		OP_COMMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic b4_zero;
	} dp_status_t;

	function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

/* design/bsc_ctrl.sv */
module bsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_cmd,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bsc_pkg::dp_cmd_t    cmd,
	input  bsc_pkg::dp_status_t status
);
	import bsc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_T_MUL, S_T_DEN, S_T_CHK, S_T_DIV, S_T_B5, S_T_TEMP,
		S_P_B6, S_P_SQ, S_P_X1, S_P_X2, S_P_B3, S_P_X1B, S_P_X2B, S_P_X3,
		S_P_B4, S_P_B7, S_P_CHK, S_P_DIV, S_P_QUO, S_P_XS, S_P_X1C, S_P_X2C,
		S_P_FIN, S_DONE
	} state_t;

	state_t     state_q;
	logic [4:0] step_q;
	logic       out_valid_q;
	logic       slot_free;
	logic       accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode the datapath operation of each state
	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE:   cmd.op = accept ? OP_LOAD : OP_NONE;
			S_T_MUL:  cmd.op = OP_T_MUL;
			S_T_DEN:  cmd.op = OP_T_DEN;
			S_T_CHK:  cmd.op = OP_T_CHK;
			S_T_DIV:  cmd.op = OP_DIV;
			S_T_B5:   cmd.op = OP_T_B5;
			S_T_TEMP: cmd.op = OP_T_TEMP;
			S_P_B6:   cmd.op = OP_P_B6;
			S_P_SQ:   cmd.op = OP_P_SQ;
			S_P_X1:   cmd.op = OP_P_X1;
			S_P_X2:   cmd.op = OP_P_X2;
			S_P_B3:   cmd.op = OP_P_B3;
			S_P_X1B:  cmd.op = OP_P_X1B;
			S_P_X2B:  cmd.op = OP_P_X2B;
			S_P_X3:   cmd.op = OP_P_X3;
			S_P_B4:   cmd.op = OP_P_B4;
			S_P_B7:   cmd.op = OP_P_B7;
			S_P_CHK:  cmd.op = OP_P_CHK;
			S_P_DIV:  cmd.op = OP_DIV;
			S_P_QUO:  cmd.op = OP_P_QUO;
			S_P_XS:   cmd.op = OP_P_XS;
			S_P_X1C:  cmd.op = OP_P_X1C;
			S_P_X2C:  cmd.op = OP_P_X2C;
			S_P_FIN:  cmd.op = OP_P_FIN;
			S_DONE:   cmd.op = slot_free ? OP_COMMIT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// Sequence the steps, count divider iterations and hold the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_RAW_TEMP:  state_q <= S_T_MUL;
							CMD_RAW_PRESS: state_q <= S_P_B6;
							default:       state_q <= S_DONE;
						endcase
					end
				end
				S_T_MUL:  state_q <= S_T_DEN;
				S_T_DEN:  state_q <= S_T_CHK;
				S_T_CHK: begin
					step_q  <= '0;
					state_q <= status.den_zero ? S_DONE : S_T_DIV;
				end
				S_T_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(DivSteps - 1)) begin
						state_q <= S_T_B5;
					end
				end
				S_T_B5:   state_q <= S_T_TEMP;
				S_T_TEMP: state_q <= S_DONE;
				S_P_B6:   state_q <= S_P_SQ;
				S_P_SQ:   state_q <= S_P_X1;
				S_P_X1:   state_q <= S_P_X2;
				S_P_X2:   state_q <= S_P_B3;
				S_P_B3:   state_q <= S_P_X1B;
				S_P_X1B:  state_q <= S_P_X2B;
				S_P_X2B:  state_q <= S_P_X3;
				S_P_X3:   state_q <= S_P_B4;
				S_P_B4:   state_q <= S_P_B7;
				S_P_B7:   state_q <= S_P_CHK;
				S_P_CHK: begin
					step_q  <= '0;
					state_q <= status.b4_zero ? S_DONE : S_P_DIV;
				end
				S_P_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(DivSteps - 1)) begin
						state_q <= S_P_QUO;
					end
				end
				S_P_QUO:  state_q <= S_P_XS;
				S_P_XS:   state_q <= S_P_X1C;
				S_P_X1C:  state_q <= S_P_X2C;
				S_P_X2C:  state_q <= S_P_FIN;
				S_P_FIN:  state_q <= S_DONE;
				S_DONE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/bsc_datapath.sv */
module bsc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [23:0]         in_sample,
	input  logic [31:0]         in_new_value,
	input  logic [1:0]          in_cmd,
	input  bsc_pkg::dp_cmd_t    cmd,
	output bsc_pkg::dp_status_t status,
	output logic [55:0]         out_data
);
	import bsc_pkg::*;

	// Configuration registers
	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;
	logic [15:0] tdelta_q, pdelta_q;

	// Architectural state
	logic [31:0] b5_q;
	logic [15:0] stemp_q;
	logic [31:0] spress_q;

	// Item and working registers
	logic [1:0]  cmd_q;
	logic [23:0] sample_q;
	logic [31:0] nv_q;
	logic        fault_q;
	logic [31:0] x1t_q, den_q, b6_q, up_q, sq_q, x1_q, x2_q, b3_q;
	logic [31:0] x1b_q, x2b_q, x3_q, b4_q, b7_q, p_q, xs_q, x1c_q, x2c_q;
	logic [15:0] t_q;
	logic        neg_q, dbl_q;

	// Divider
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [32:0] div_sh;
	logic [32:0] div_diff;

	// Shared multiplier
	logic [31:0] mul_a, mul_b, prod;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] num, num_abs, den_abs, quo_signed, t_pre, p_fin;
	logic [31:0] up_next, b7_scale, pdiff, xa;
	logic [15:0] tdiff;
	logic        t_chg, p_chg;

	assign ac1 = sx16(ac12_q[31:16]);
	assign ac2 = sx16(ac12_q[15:0]);
	assign ac3 = sx16(ac34_q[31:16]);
	assign ac4 = {16'd0, ac34_q[15:0]};
	assign ac5 = {16'd0, ac56_q[31:16]};
	assign ac6 = {16'd0, ac56_q[15:0]};
	assign b1  = sx16(b12_q[31:16]);
	assign b2  = sx16(b12_q[15:0]);
	assign mc  = sx16(mcmd_q[31:16]);
	assign md  = sx16(mcmd_q[15:0]);

	assign num     = {mc[20:0], 11'd0};
	assign num_abs = num[31] ? (32'd0 - num) : num;
	assign den_abs = den_q[31] ? (32'd0 - den_q) : den_q;
	assign quo_signed = neg_q ? (32'd0 - quo_q) : quo_q;
	assign t_pre   = asr32(b5_q + T5Round, 4);
	assign xa      = asr32(p_q, 8);
	assign p_fin   = p_q + asr32(x1c_q + x2c_q + CoefMi, 4);

	assign status.den_zero = (den_q == 32'd0);
	assign status.b4_zero  = (b4_q == 32'd0);

	// Raw pressure sample and b7 scale by oversampling
	always_comb begin
		case (oss_q)
			2'd0:    up_next = {8'd0, 8'd0, sample_q[23:8]};
			2'd1:    up_next = {8'd0, 7'd0, sample_q[23:7]};
			2'd2:    up_next = {8'd0, 6'd0, sample_q[23:6]};
			default: up_next = {8'd0, 5'd0, sample_q[23:5]};
		endcase
		case (oss_q)
			2'd0:    b7_scale = 32'd50000;
			2'd1:    b7_scale = 32'd25000;
			2'd2:    b7_scale = 32'd12500;
			default: b7_scale = 32'd6250;
		endcase
	end

	// Select multiplier operands
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (cmd.op)
			OP_T_MUL: begin
				mul_a = {16'd0, sample_q[15:0]} - ac6;
				mul_b = ac5;
			end
			OP_P_SQ: begin
				mul_a = b6_q;
				mul_b = b6_q;
			end
			OP_P_X1: begin
				mul_a = sq_q;
				mul_b = b2;
			end
			OP_P_X2: begin
				mul_a = ac2;
				mul_b = b6_q;
			end
			OP_P_X1B: begin
				mul_a = ac3;
				mul_b = b6_q;
			end
			OP_P_X2B: begin
				mul_a = b1;
				mul_b = sq_q;
			end
			OP_P_B4: begin
				mul_a = ac4;
				mul_b = x3_q + B4Offset;
			end
			OP_P_B7: begin
				mul_a = up_q - b3_q;
				mul_b = b7_scale;
			end
			OP_P_XS: begin
				mul_a = xa;
				mul_b = xa;
			end
			OP_P_X1C: begin
				mul_a = xs_q;
				mul_b = CoefMg;
			end
			OP_P_X2C: begin
				mul_a = p_q;
				mul_b = 32'd0 - CoefMhNeg;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign div_sh   = {rem_q, quo_q[31]};
	assign div_diff = div_sh - {1'b0, dvs_q};

	// Change detection against the stored values
	assign tdiff = (t_q > stemp_q) ? (t_q - stemp_q) : (stemp_q - t_q);
	assign t_chg = (tdiff > tdelta_q);
	assign pdiff = (p_q > spress_q) ? (p_q - spress_q) : (spress_q - p_q);
	assign p_chg = (pdiff > {16'd0, pdelta_q});

	// Hold configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q   <= '0;
			ac34_q   <= '0;
			ac56_q   <= '0;
			b12_q    <= '0;
			mcmd_q   <= '0;
			oss_q    <= '0;
			tdelta_q <= 16'd1;
			pdelta_q <= 16'd20;
			b5_q     <= '0;
			stemp_q  <= '0;
			spress_q <= '0;
			fault_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_AC1_AC2: ac12_q   <= cfg_data;
					REG_AC3_AC4: ac34_q   <= cfg_data;
					REG_AC5_AC6: ac56_q   <= cfg_data;
					REG_B1_B2:   b12_q    <= cfg_data;
					REG_MC_MD:   mcmd_q   <= cfg_data;
					REG_OSS:     oss_q    <= cfg_data[1:0];
					REG_TDELTA:  tdelta_q <= cfg_data[15:0];
					REG_PDELTA:  pdelta_q <= cfg_data[15:0];
					default:     ;
				endcase
			end
			case (cmd.op)
				OP_LOAD:  fault_q <= 1'b0;
				OP_T_CHK: fault_q <= status.den_zero;
				OP_P_CHK: fault_q <= status.b4_zero;
				OP_T_B5:  b5_q <= x1t_q + quo_signed;
				OP_COMMIT: begin
					case (cmd_q)
						CMD_RAW_TEMP:  if (!fault_q && t_chg) stemp_q <= t_q;
						CMD_RAW_PRESS: if (!fault_q && p_chg) spress_q <= p_q;
						CMD_SET_TEMP:  stemp_q <= nv_q[15:0];
						default:       spress_q <= nv_q;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Advance the working registers and the divider
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cmd_q    <= in_cmd;
				sample_q <= in_sample;
				nv_q     <= in_new_value;
			end
			OP_T_MUL: x1t_q <= asr32(prod, 15);
			OP_T_DEN: den_q <= x1t_q + md;
			OP_T_CHK: begin
				rem_q <= '0;
				quo_q <= num_abs;
				dvs_q <= den_abs;
				neg_q <= num[31] ^ den_q[31];
			end
			OP_DIV: begin
				if (!div_diff[32]) begin
					rem_q <= div_diff[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= div_sh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			OP_T_TEMP: t_q <= t_pre[15:0];
			OP_P_B6: begin
				b6_q <= b5_q - B6Offset;
				up_q <= up_next;
			end
			OP_P_SQ:  sq_q <= asr32(prod, 12);
			OP_P_X1:  x1_q <= asr32(prod, 11);
			OP_P_X2:  x2_q <= asr32(prod, 11);
			OP_P_B3:  b3_q <= asr32((((ac1 << 2) + x1_q + x2_q) << oss_q) + 32'd2, 2);
			OP_P_X1B: x1b_q <= asr32(prod, 13);
			OP_P_X2B: x2b_q <= asr32(prod, 16);
			OP_P_X3:  x3_q <= asr32(x1b_q + x2b_q + 32'd2, 2);
			OP_P_B4:  b4_q <= prod >> 15;
			OP_P_B7:  b7_q <= prod;
			OP_P_CHK: begin
				rem_q <= '0;
				dbl_q <= !(b7_q < B7Limit);
				quo_q <= (b7_q < B7Limit) ? (b7_q << 1) : b7_q;
				dvs_q <= b4_q;
			end
			OP_P_QUO: p_q <= dbl_q ? (quo_q << 1) : quo_q;
			OP_P_XS:  xs_q <= prod;
			OP_P_X1C: x1c_q <= asr32(prod, 16);
			OP_P_X2C: x2c_q <= asr32(prod, 16);
			OP_P_FIN: p_q <= p_fin;
			default: ;
		endcase
	end

	// Capture the result beat as the stored values are committed
	always_ff @(posedge clk) begin
		if (cmd.op == OP_COMMIT) begin
			out_data[55:50] <= '0;
			out_data[1]     <= fault_q;
			case (cmd_q)
				CMD_RAW_TEMP: begin
					out_data[0]     <= !fault_q && t_chg;
					out_data[17:2]  <= (!fault_q && t_chg) ? t_q : stemp_q;
					out_data[49:18] <= spress_q;
				end
				CMD_RAW_PRESS: begin
					out_data[0]     <= !fault_q && p_chg;
					out_data[17:2]  <= stemp_q;
					out_data[49:18] <= (!fault_q && p_chg) ? p_q : spress_q;
				end
				CMD_SET_TEMP: begin
					out_data[0]     <= 1'b0;
					out_data[17:2]  <= nv_q[15:0];
					out_data[49:18] <= spress_q;
				end
				default: begin
					out_data[0]     <= 1'b0;
					out_data[17:2]  <= stemp_q;
					out_data[49:18] <= nv_q;
				end
			endcase
		end
	end

endmodule

/* design/barometric_sensor_compensation.sv */
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   tuser: command; tdata: sample, new_value
// m_*       out        m_tvalid / m_tready   tdata: changed, fault, temperature, pressure
// cfg_*     in         cfg_valid / cfg_ready index 0..7, 32-bit data
//
// One item at a time; a set command goes straight to its result, and a zero divisor
// skips the division. The 32-step shared divider serves raw temperature and raw pressure.
// Asynchronous active-low reset clears configuration but sets the deltas to 1 and 20,
// and clears b5 and stored values. A result waits in the output register; the next beat is
// taken meanwhile, and its result is held back until the previous one has been taken.
module barometric_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // sample[23:0], new_value[55:24]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // changed[0], division_fault[1], temperature[17:2],
	                              // pressure[49:18], zero[55:50]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import bsc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	bsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_cmd    (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

	bsc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_sample    (s_tdata[23:0]),
		.in_new_value (s_tdata[55:24]),
		.in_cmd       (s_tuser),
		.cmd          (cmd),
		.status       (status),
		.out_data     (m_tdata)
	);

endmodule

/* design/bsc_checker.sv */
`include "barometric_sensor_compensation_macros.svh"

module bsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// A stalled result beat stays offered
	`BSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

	// A dropped sample never reports a change
	`BSC_ASSERT_SAME(a_fault_no_change, m_tvalid, !(m_tdata[0] && m_tdata[1]))

	// One item at a time: busy right after an accepted beat
	`BSC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

	// A result only follows work: none can appear while idle and empty
	`BSC_ASSERT_NEXT(a_no_spurious_out, !m_tvalid && s_tready && !s_tvalid, !m_tvalid)

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);

/* verif/bsc_checker.sv */
module bsc_tb_checker
	import bsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          open_count,
	output int          result_count,
	output int          fault_count,
	output int          change_count
);

	typedef struct packed {
		logic        changed;
		logic        fault;
		logic [15:0] temperature;
		logic [31:0] pressure;
	} reading_t;

	reading_t    expected_readings[$];
	logic [31:0] cal_regs [8];
	logic [31:0] b5_term;
	logic [15:0] temp_held;
	logic [31:0] press_held;

	function automatic logic [31:0] shr_arith(input logic [31:0] v, input int n);
		return $unsigned($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] ext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] dist32(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
			result_count, what, got, want);
		fail_count++;
	endtask

	// Compensate one input beat and queue the reading it should produce
	task automatic compensate_beat(input logic [1:0] cmd, input logic [23:0] sample,
			input logic [31:0] nv);
		reading_t r;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, den, b6, sq, b3, b4, b7, up, p, t;
		int oss;
		longint q;
		r = '0;
		ac1 = ext16(cal_regs[REG_AC1_AC2][31:16]);
		ac2 = ext16(cal_regs[REG_AC1_AC2][15:0]);
		ac3 = ext16(cal_regs[REG_AC3_AC4][31:16]);
		ac4 = {16'd0, cal_regs[REG_AC3_AC4][15:0]};
		ac5 = {16'd0, cal_regs[REG_AC5_AC6][31:16]};
		ac6 = {16'd0, cal_regs[REG_AC5_AC6][15:0]};
		b1 = ext16(cal_regs[REG_B1_B2][31:16]);
		b2 = ext16(cal_regs[REG_B1_B2][15:0]);
		mc = ext16(cal_regs[REG_MC_MD][31:16]);
		md = ext16(cal_regs[REG_MC_MD][15:0]);
		oss = int'(cal_regs[REG_OSS][1:0]);
		case (cmd)
			CMD_RAW_TEMP: begin
				x1 = shr_arith(({16'd0, sample[15:0]} - ac6) * ac5, 15);
				den = x1 + md;
				if (den == 0) begin
					r.fault = 1'b1;
				end else begin
					q = (longint'($signed(mc)) * 2048) / longint'($signed(den));
					b5_term = x1 + q[31:0];
					t = shr_arith(b5_term + T5Round, 4) & 32'hFFFF;
					if (dist32(t, {16'd0, temp_held}) > cal_regs[REG_TDELTA]) begin
						temp_held = t[15:0];
						r.changed = 1'b1;
					end
				end
			end
			CMD_RAW_PRESS: begin
				up = {8'd0, sample} >> (8 - oss);
				b6 = b5_term - B6Offset;
				sq = shr_arith(b6 * b6, 12);
				x1 = shr_arith(sq * b2, 11);
				x2 = shr_arith(ac2 * b6, 11);
				x3 = x1 + x2;
				b3 = shr_arith(((ac1 * 4 + x3) << oss) + 2, 2);
				x1 = shr_arith(ac3 * b6, 13);
				x2 = shr_arith(b1 * sq, 16);
				x3 = shr_arith(x1 + x2 + 2, 2);
				b4 = (ac4 * (x3 + B4Offset)) >> 15;
				b7 = (up - b3) * (32'd50000 >> oss);
				if (b4 == 0) begin
					r.fault = 1'b1;
				end else begin
					if (b7 < B7Limit)
						p = (b7 << 1) / b4;
					else
						p = (b7 / b4) << 1;
					x1 = shr_arith(p, 8);
					x1 = x1 * x1;
					x1 = shr_arith(x1 * CoefMg, 16);
					x2 = shr_arith(p * (32'd0 - CoefMhNeg), 16);
					p = p + shr_arith(x1 + x2 + CoefMi, 4);
					if (dist32(p, press_held) > cal_regs[REG_PDELTA]) begin
						press_held = p;
						r.changed = 1'b1;
					end
				end
			end
			CMD_SET_TEMP: temp_held = nv[15:0];
			default: press_held = nv;
		endcase
		r.temperature = temp_held;
		r.pressure = press_held;
		expected_readings.push_back(r);
	endtask

	// Track configuration, predict on input beats, compare output beats
	always @(posedge clk or negedge arst_n) begin
		reading_t want, got;
		if (!arst_n) begin
			foreach (cal_regs[i]) cal_regs[i] = '0;
			cal_regs[REG_TDELTA] = 32'd1;
			cal_regs[REG_PDELTA] = 32'd20;
			b5_term = '0;
			temp_held = '0;
			press_held = '0;
			expected_readings.delete();
			open_count = 0;
			fail_count = 0;
			result_count = 0;
			fault_count = 0;
			change_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OSS: cal_regs[cfg_index] = cfg_data & 32'h3;
					REG_TDELTA, REG_PDELTA: cal_regs[cfg_index] = cfg_data & 32'hFFFF;
					default: cal_regs[cfg_index] = cfg_data;
				endcase
			end
			if (s_tvalid && s_tready)
				compensate_beat(s_tuser, s_tdata[23:0], s_tdata[55:24]);
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[1], m_tdata[17:2], m_tdata[49:18]};
				if (expected_readings.size() == 0) begin
					report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
				end else begin
					want = expected_readings.pop_front();
					if (got.changed !== want.changed)
						report_mismatch("changed", 32'(got.changed), 32'(want.changed));
					if (got.fault !== want.fault)
						report_mismatch("division_fault", 32'(got.fault),
							32'(want.fault));
					if (got.temperature !== want.temperature)
						report_mismatch("temperature", {16'd0, got.temperature},
							{16'd0, want.temperature});
					if (got.pressure !== want.pressure)
						report_mismatch("pressure", got.pressure, want.pressure);
					fault_count += int'(want.fault);
					change_count += int'(want.changed);
				end
				result_count++;
			end
			open_count = expected_readings.size();
		end
	end

endmodule

/* verif/barometric_sensor_compensation_test.sv */
module barometric_sensor_compensation_test;
	import bsc_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int RandomItems = 1880;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // sample[23:0], new_value[55:24]
	logic [1:0]  s_tuser;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // changed[0], division_fault[1], temperature[17:2],
	                        // pressure[49:18], zero[55:50]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int fail_count, open_count, result_count, fault_count, change_count;
	int cycles;
	int items_sent;
	bit calm;
	bit hold_go;

	barometric_sensor_compensation u_top (.*);

	bsc_tb_checker u_checker (.*);

	// Clock and the single reset at start
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Drive result ready: random stalls, one long hold-off on request
	initial begin
		int hold;
		bit held;
		m_tready = 1'b0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				hold = 600;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 17);
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		bit rdy;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_beat(input logic [1:0] cmd, input logic [23:0] sample,
			input logic [31:0] nv);
		bit rdy;
		if (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {nv, sample};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		items_sent++;
	endtask

	// Drop valid and let the block drain before touching registers
	task automatic drain;
		s_tvalid <= 1'b0;
		while (open_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Typical calibration with some jitter
	task automatic load_calibration(input int jitter);
		write_reg(REG_AC1_AC2, {16'(408 + $urandom_range(jitter) - jitter / 2),
			16'(-72 + $urandom_range(jitter) - jitter / 2)});
		write_reg(REG_AC3_AC4, {16'(-14383 + $urandom_range(jitter) - jitter / 2),
			16'(32741 - $urandom_range(jitter))});
		write_reg(REG_AC5_AC6, {16'(32757 - $urandom_range(jitter)),
			16'(23153 + $urandom_range(jitter))});
		write_reg(REG_B1_B2, {16'(6190 + $urandom_range(jitter)), 16'(4)});
		write_reg(REG_MC_MD, {16'(-8711 + $urandom_range(jitter)),
			16'(2868 + $urandom_range(jitter))});
	endtask

	// Mostly plausible raw readings, some noise and software writes
	task automatic random_beat(input int oss);
		int pick;
		logic [23:0] smp;
		pick = $urandom_range(99);
		smp = 24'($urandom);
		if (pick < 40) begin
			if ($urandom_range(4) != 0)
				smp = {smp[23:16], 16'(27898 + $urandom_range(4000) - 2000)};
			send_beat(CMD_RAW_TEMP, smp, $urandom);
		end else if (pick < 85) begin
			if ($urandom_range(4) != 0)
				smp = (24'(23843 + $urandom_range(6000) - 3000) << oss << (8 - oss))
					| (smp & 24'hFF);
			send_beat(CMD_RAW_PRESS, smp, $urandom);
		end else if (pick < 93) begin
			send_beat(CMD_SET_TEMP, smp, $urandom);
		end else begin
			send_beat(CMD_SET_PRESS, smp, $urandom);
		end
	endtask

	// Stimulus and verdict
	initial begin
		int oss;
		logic [15:0] tdelta [5];
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_RAW_TEMP;
		cfg_valid = 1'b0;
		cfg_index = REG_AC1_AC2;
		cfg_data = '0;
		calm = 1'b0;
		hold_go = 1'b0;
		items_sent = 0;
		tdelta = '{16'd0, 16'd1, 16'd5, 16'd65535, 16'd200};
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Reset calibration: both divisors are zero
		send_beat(CMD_RAW_TEMP, 24'hFFFFFF, 32'd0);
		send_beat(CMD_RAW_PRESS, 24'hFFFFFF, 32'd0);
		send_beat(CMD_SET_TEMP, 24'd0, 32'hFFFF_FFFF);
		send_beat(CMD_SET_PRESS, 24'd0, 32'hFFFF_FFFF);
		send_beat(CMD_SET_TEMP, 24'hFFFFFF, 32'd0);
		send_beat(CMD_SET_PRESS, 24'hFFFFFF, 32'd0);
		drain();

		// Typical calibration, no deltas, field extremes
		load_calibration(0);
		write_reg(REG_OSS, 32'hFFFF_FFFC);
		write_reg(REG_TDELTA, 32'hFFFF_0000);
		write_reg(REG_PDELTA, 32'd0);
		send_beat(CMD_RAW_TEMP, 24'd27898, 32'd0);
		send_beat(CMD_RAW_PRESS, 24'd23843 << 8, 32'd0);
		send_beat(CMD_RAW_TEMP, 24'hFF0000 | 24'd27898, 32'd0);
		send_beat(CMD_RAW_PRESS, 24'hFFFFFF, 32'd0);
		send_beat(CMD_RAW_PRESS, 24'd0, 32'd0);
		send_beat(CMD_RAW_TEMP, 24'd0, 32'd0);
		send_beat(CMD_RAW_TEMP, 24'h00FFFF, 32'd0);
		send_beat(CMD_RAW_PRESS, 24'd23843 << 8, 32'd0);
		drain();

		// Zero temperature divisor with otherwise sane words, then zero b4
		write_reg(REG_MC_MD, {16'(-8711), 16'd0});
		send_beat(CMD_RAW_TEMP, 24'd23153, 32'd0);
		send_beat(CMD_RAW_TEMP, 24'd27898, 32'd0);
		drain();
		write_reg(REG_AC3_AC4, {16'(-14383), 16'd0});
		send_beat(CMD_RAW_PRESS, 24'd23843 << 8, 32'd0);
		drain();

		// Full-scale words and the highest oversampling
		write_reg(REG_AC1_AC2, 32'hFFFF_FFFF);
		write_reg(REG_AC3_AC4, 32'h8000_FFFF);
		write_reg(REG_AC5_AC6, 32'hFFFF_0000);
		write_reg(REG_B1_B2, 32'h7FFF_8000);
		write_reg(REG_MC_MD, 32'h7FFF_7FFF);
		write_reg(REG_OSS, 32'd3);
		write_reg(REG_TDELTA, 32'd65535);
		write_reg(REG_PDELTA, 32'd65535);
		send_beat(CMD_RAW_TEMP, 24'hFFFFFF, 32'd0);
		send_beat(CMD_RAW_PRESS, 24'hFFFFFF, 32'd0);
		send_beat(CMD_RAW_TEMP, 24'd0, 32'd0);
		send_beat(CMD_RAW_PRESS, 24'h000001, 32'd0);
		drain();

		// Random phases, each with its own setting
		for (int ph = 0; ph < 6; ph++) begin
			oss = (ph == 0) ? 0 : (ph == 1) ? 3 : $urandom_range(3);
			if (ph == 5) begin
				for (int r = 0; r < 5; r++) write_reg(3'(r), $urandom);
			end else begin
				load_calibration(ph * 40);
			end
			write_reg(REG_OSS, 32'(oss));
			write_reg(REG_TDELTA, {16'd0, tdelta[ph % 5]});
			write_reg(REG_PDELTA, (ph == 2) ? 32'd65535 : 32'($urandom_range(60)));
			for (int n = 0; n < RandomItems / 6; n++) begin
				calm = (ph == 2) && (n > 50) && (n < 200);
				if (ph == 3 && n == 40)
					hold_go = 1'b1;
				random_beat(oss);
			end
			calm = 1'b0;
			drain();
		end

		while (open_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d beats over several calibration and delta settings;", items_sent);
		$display("checked %0d readings, %0d with a fault, %0d with a change",
			result_count, fault_count, change_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
